FILE: rtl/bitmap_frame_allocator_top_macros.svh
// Assertion wrappers for the frame allocator. Sampled on clk.
// BFA_CHECK is disabled while rst_n is low; BFA_CHECK_ALWAYS holds in reset too.
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BFA_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFA_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFA_CHECK(label, prop, msg)
`define BFA_CHECK_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/bfa_pkg.sv
package bfa_pkg;

    localparam int unsigned FRAME_BYTES_DEF  = 4096;
    localparam int unsigned BITMAP_BYTES_DEF = 4096;

    localparam int DIVIDEND_W = 33;   // byte address plus rounding carry
    localparam int ADDR_MAX_W = 16;   // largest bitmap is 64K bytes
    localparam int FRAME_W    = 15;

    localparam logic [7:0] BYTE_FULL  = 8'hFF;
    localparam logic [7:0] BYTE_EMPTY = 8'h00;
    localparam logic [7:0] BIT_FIRST  = 8'h80;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE      = 2'd1,
        OP_MARK_FREE = 2'd2,
        OP_MARK_USED = 2'd3
    } op_t;

    typedef enum logic {
        STATUS_OK      = 1'b0,
        STATUS_NO_FREE = 1'b1
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_SETUP,
        S_RD,
        S_WR,
        S_DONE
    } state_t;

    // One access per cycle: either a read or a write at addr.
    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] addr;
        logic [7:0]            wdata;
    } mem_req_t;

endpackage

FILE: rtl/bfa_div.sv
module bfa_div #(
    parameter int unsigned DIVISOR = bfa_pkg::FRAME_BYTES_DEF,
    parameter int unsigned QW      = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [bfa_pkg::DIVIDEND_W-1:0]  dividend,
    output logic                            done,
    output logic [QW-1:0]                   quotient
);

    localparam int DW   = bfa_pkg::DIVIDEND_W;
    localparam int MW   = DW + 1;
    localparam int HW   = MW / 2;
    localparam int PW   = DW + HW;
    localparam int ACCW = DW + MW;
    localparam int SH   = DW + $clog2(DIVISOR);
    // ceil(2^SH / DIVISOR) gives the exact quotient for every DW-bit dividend
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP_V  = MW'(RECIP);
    localparam logic [HW-1:0] RECIP_LO = RECIP_V[HW-1:0];
    localparam logic [HW-1:0] RECIP_HI = RECIP_V[MW-1:HW];

    logic            lo_pend_reg, lo_pend_next;
    logic            hi_pend_reg, hi_pend_next;
    logic            done_reg, done_next;
    logic [DW-1:0]   dvd_reg, dvd_next;
    logic [ACCW-1:0] acc_reg, acc_next;

    logic [HW-1:0]   coef;
    logic [PW-1:0]   prod;

    // multiply by the reciprocal in two halves, low half first
    always_comb
    begin
        coef = hi_pend_reg ? RECIP_HI : RECIP_LO;
        prod = PW'(dvd_reg) * PW'(coef);

        lo_pend_next = start;
        hi_pend_next = lo_pend_reg;
        done_next    = hi_pend_reg;
        dvd_next     = start ? dividend : dvd_reg;
        acc_next     = acc_reg;

        if (lo_pend_reg)
            acc_next = ACCW'(prod);
        else if (hi_pend_reg)
            acc_next = acc_reg + (ACCW'(prod) << HW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_pend_reg <= 1'b0;
            hi_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            lo_pend_reg <= lo_pend_next;
            hi_pend_reg <= hi_pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign quotient = QW'(acc_reg >> SH);

endmodule

FILE: rtl/bfa_bitmap.sv
module bfa_bitmap #(
    parameter int unsigned DEPTH = bfa_pkg::BITMAP_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bfa_pkg::mem_req_t req,
    output logic [7:0]        rdata,
    output logic              init_busy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;

    // after reset every byte is swept to all-used before the first request
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
                clr_busy_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + 1'b1;
        end

        we = clr_busy_reg | req.wr_en;
        wa = clr_busy_reg ? clr_addr_reg : req.addr[AW-1:0];
        wd = clr_busy_reg ? bfa_pkg::BYTE_FULL : req.wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (req.rd_en)
            rdata_reg <= mem[req.addr[AW-1:0]];
    end

    assign rdata     = rdata_reg;
    assign init_busy = clr_busy_reg;

endmodule

FILE: rtl/bitmap_frame_allocator_top.sv
// Next-fit page frame allocator over a one-bit-per-frame bitmap held in a
// single-port synchronous RAM (frame i of a byte is bit 7-i, set = used).
// After reset the RAM is swept to all-used, one byte per cycle, so no item
// is taken until the sweep is done. Items are handled one at a time. Allocate
// reads one byte per cycle starting at the rover until a byte with a free
// frame turns up, reading up to BITMAP_BYTES bytes when the map is full.
// Free read-modify-writes the frame's byte and skips the RAM when the
// frame lies beyond the bitmap. The two range ops first turn both addresses
// into frame numbers with a two-step multiply by the reciprocal of
// FRAME_BYTES, pass a setup state, then visit each covered bitmap byte: a
// whole byte is written without a read, a partial one by read-modify-write,
// and a last state posts the result. The result sits in an output register,
// so the next item can enter while it waits to be taken.
`include "bitmap_frame_allocator_top_macros.svh"

module bitmap_frame_allocator_top #(
    parameter int unsigned FRAME_BYTES  = bfa_pkg::FRAME_BYTES_DEF,
    parameter int unsigned BITMAP_BYTES = bfa_pkg::BITMAP_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [14:0] frame_index,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [14:0] granted_frame
);

    localparam int AW     = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int AMW    = bfa_pkg::ADDR_MAX_W;
    localparam int FW     = bfa_pkg::FRAME_W;
    localparam int DW     = bfa_pkg::DIVIDEND_W;
    localparam int QW_DIV = 34 - $clog2(FRAME_BYTES + 1);
    localparam int QW_A   = (QW_DIV > AW + 4) ? QW_DIV : AW + 4;
    localparam int QW     = (QW_A > FW) ? QW_A : FW;
    localparam int unsigned FRAME_LIMIT = BITMAP_BYTES * 8;

    bfa_pkg::state_t state_reg, state_next;
    bfa_pkg::op_t    op_reg, op_next;
    logic [QW-1:0]   first_reg, first_next;
    logic [QW-1:0]   last_reg, last_next;
    logic [AW-1:0]   cur_reg, cur_next;
    logic [AW-1:0]   end_reg, end_next;
    logic [AW-1:0]   rover_reg, rover_next;
    logic [AW-1:0]   iss_reg, iss_next;
    logic [AW-1:0]   chk_addr_reg, chk_addr_next;
    logic [AW-1:0]   chk_cnt_reg, chk_cnt_next;
    logic            chk_vld_reg, chk_vld_next;
    logic            res_status_reg, res_status_next;
    logic [FW-1:0]   res_grant_reg, res_grant_next;
    logic            out_valid_reg, out_valid_next;
    logic            status_reg, status_next;
    logic [FW-1:0]   granted_reg, granted_next;

    logic            div_start;
    logic [DW-1:0]   end_dividend;
    logic [QW-1:0]   q_start, q_end;
    logic            done_s, done_e;
    logic            div_done;

    bfa_pkg::mem_req_t mem_req;
    logic [7:0]        mem_rdata;
    logic              init_busy;

    logic [QW-1:0]   last_clamp;
    logic            range_empty;
    logic [2:0]      lo_bit, hi_bit;
    logic [7:0]      range_mask;
    logic            mark_used;
    logic [7:0]      merged;
    logic [7:0]      full_fill;
    logic [2:0]      free_idx;
    logic            byte_full;
    logic [AW+2:0]   grant_bits;
    logic [AW-1:0]   iss_inc;
    logic            in_xfer;

    assign div_done = done_s & done_e;
    assign in_ready = (state_reg == bfa_pkg::S_IDLE) && !init_busy;
    assign in_xfer  = in_valid && in_ready;

    assign end_dividend = (bfa_pkg::op_t'(op) == bfa_pkg::OP_MARK_USED)
                        ? DW'(range_end) + DW'(FRAME_BYTES - 1)
                        : DW'(range_end);

    bfa_div #(
        .DIVISOR (FRAME_BYTES),
        .QW      (QW)
    ) u_div_start (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DW'(range_start)),
        .done     (done_s),
        .quotient (q_start)
    );

    bfa_div #(
        .DIVISOR (FRAME_BYTES),
        .QW      (QW)
    ) u_div_end (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (end_dividend),
        .done     (done_e),
        .quotient (q_end)
    );

    bfa_bitmap #(
        .DEPTH (BITMAP_BYTES)
    ) u_bitmap (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mem_req),
        .rdata     (mem_rdata),
        .init_busy (init_busy)
    );

    // datapath helpers
    always_comb
    begin
        last_clamp  = (last_reg >= QW'(FRAME_LIMIT)) ? QW'(FRAME_LIMIT - 1) : last_reg;
        range_empty = first_reg > last_clamp;

        lo_bit = (cur_reg == first_reg[AW+2:3]) ? first_reg[2:0] : 3'd0;
        hi_bit = (cur_reg == end_reg) ? last_reg[2:0] : 3'd7;
        for (int i = 0; i < 8; i++)
            range_mask[7-i] = (3'(i) >= lo_bit) && (3'(i) <= hi_bit);

        mark_used = op_reg == bfa_pkg::OP_MARK_USED;
        merged    = mark_used ? (mem_rdata | range_mask) : (mem_rdata & ~range_mask);
        full_fill = mark_used ? bfa_pkg::BYTE_FULL : bfa_pkg::BYTE_EMPTY;

        // lowest-numbered free frame sits at the highest clear bit
        free_idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!mem_rdata[7-i])
                free_idx = 3'(i);
        end
        byte_full  = mem_rdata == bfa_pkg::BYTE_FULL;
        grant_bits = {chk_addr_reg, free_idx};

        iss_inc = (iss_reg == AW'(BITMAP_BYTES - 1)) ? '0 : iss_reg + 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        rover_next      = rover_reg;
        iss_next        = iss_reg;
        chk_addr_next   = chk_addr_reg;
        chk_cnt_next    = chk_cnt_reg;
        chk_vld_next    = chk_vld_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        granted_next    = granted_reg;
        div_start       = 1'b0;
        mem_req         = '0;

        case (state_reg)
            bfa_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next         = bfa_pkg::op_t'(op);
                    res_status_next = bfa_pkg::STATUS_OK;
                    res_grant_next  = '0;
                    case (bfa_pkg::op_t'(op))
                        bfa_pkg::OP_ALLOC:
                        begin
                            iss_next     = rover_reg;
                            chk_vld_next = 1'b0;
                            chk_cnt_next = '0;
                            state_next   = bfa_pkg::S_SCAN;
                        end
                        bfa_pkg::OP_FREE:
                        begin
                            first_next = QW'(frame_index);
                            last_next  = QW'(frame_index);
                            state_next = bfa_pkg::S_SETUP;
                        end
                        default:
                        begin
                            div_start  = 1'b1;
                            state_next = bfa_pkg::S_DIV;
                        end
                    endcase
                end
            end

            bfa_pkg::S_SCAN:
            begin
                if (chk_vld_reg && !byte_full)
                begin
                    mem_req.wr_en  = 1'b1;
                    mem_req.addr   = AMW'(chk_addr_reg);
                    mem_req.wdata  = mem_rdata | (bfa_pkg::BIT_FIRST >> free_idx);
                    rover_next     = chk_addr_reg;
                    res_grant_next = FW'(grant_bits);
                    state_next     = bfa_pkg::S_DONE;
                end
                else if (chk_vld_reg && chk_cnt_reg == AW'(BITMAP_BYTES - 1))
                begin
                    res_status_next = bfa_pkg::STATUS_NO_FREE;
                    state_next      = bfa_pkg::S_DONE;
                end
                else
                begin
                    // one read in flight each cycle; data returns next cycle
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = AMW'(iss_reg);
                    chk_addr_next = iss_reg;
                    chk_vld_next  = 1'b1;
                    iss_next      = iss_inc;
                    if (chk_vld_reg)
                        chk_cnt_next = chk_cnt_reg + 1'b1;
                end
            end

            bfa_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    first_next = q_start;
                    last_next  = q_end;
                    state_next = bfa_pkg::S_SETUP;
                end
            end

            bfa_pkg::S_SETUP:
            begin
                if (range_empty)
                    state_next = bfa_pkg::S_DONE;
                else
                begin
                    last_next  = last_clamp;
                    cur_next   = first_reg[AW+2:3];
                    end_next   = last_clamp[AW+2:3];
                    state_next = bfa_pkg::S_RD;
                end
            end

            bfa_pkg::S_RD:
            begin
                if (range_mask == bfa_pkg::BYTE_FULL)
                begin
                    // whole byte covered, no need to read it
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = AMW'(cur_reg);
                    mem_req.wdata = full_fill;
                    if (cur_reg == end_reg)
                        state_next = bfa_pkg::S_DONE;
                    else
                        cur_next = cur_reg + 1'b1;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = AMW'(cur_reg);
                    state_next    = bfa_pkg::S_WR;
                end
            end

            bfa_pkg::S_WR:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = AMW'(cur_reg);
                mem_req.wdata = merged;
                if (cur_reg == end_reg)
                    state_next = bfa_pkg::S_DONE;
                else
                begin
                    cur_next   = cur_reg + 1'b1;
                    state_next = bfa_pkg::S_RD;
                end
            end

            bfa_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    granted_next   = res_grant_reg;
                    state_next     = bfa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfa_pkg::S_IDLE;
            rover_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        cur_reg        <= cur_next;
        end_reg        <= end_next;
        iss_reg        <= iss_next;
        chk_addr_reg   <= chk_addr_next;
        chk_cnt_reg    <= chk_cnt_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_frame = granted_reg;

    `BFA_CHECK_ALWAYS(a_one_access, !(mem_req.rd_en && mem_req.wr_en), "read and write in same cycle")
    `BFA_CHECK(a_nofree_zero, out_valid && status |-> granted_frame == '0, "no-free result carries a frame")
    `BFA_CHECK(a_rover_on_grant, rover_reg != $past(rover_reg) |-> $past(state_reg) == bfa_pkg::S_SCAN, "rover moved outside allocate")

endmodule

FILE: tb/tb_bitmap_frame_allocator_top.sv
module tb_bitmap_frame_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned     FRAME_SZ       = bfa_pkg::FRAME_BYTES_DEF;
    localparam int unsigned     MAP_BYTES      = bfa_pkg::BITMAP_BYTES_DEF;
    localparam longint unsigned MAP_FRAMES     = longint'(MAP_BYTES) * 8;
    localparam int              RANDOM_ITEMS   = 1930;
    localparam int              PHASE_LEN      = 120;
    // covers the reset sweep, then a full-map scan or range op
    localparam int              WATCHDOG_LIMIT = 40000;
    localparam int              DRAIN_CYCLES   = 20;
    localparam int              MAX_REPORTS    = 10;

    typedef struct packed {
        bfa_pkg::op_t op;
        logic [14:0]  frame;
        logic [31:0]  start;
        logic [31:0]  stop;
    } frame_req_t;

    typedef struct packed {
        bfa_pkg::status_t status;
        logic [14:0]      grant;
    } frame_rsp_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  op            = bfa_pkg::OP_ALLOC;
    logic [14:0] frame_index   = '0;
    logic [31:0] range_start   = '0;
    logic [31:0] range_end     = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        status;
    logic [14:0] granted_frame;

    frame_req_t  req_q[$];
    frame_rsp_t  grant_q[$];
    frame_req_t  cur_req;
    logic        in_fire       = 1'b0;
    int          issued_cnt    = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches    = 0;
    int          quiet_cycles  = 0;

    // shadow copy of the allocator state
    logic [7:0]  shadow_map [MAP_BYTES];
    int unsigned shadow_rover;

    bitmap_frame_allocator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .frame_index   (frame_index),
        .range_start   (range_start),
        .range_end     (range_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_frame (granted_frame)
    );

    always #5 clk = ~clk;

    function automatic void set_shadow_frame(longint unsigned f, logic used);
        longint unsigned b;
        logic [7:0]      mask;
        b = f >> 3;
        if (b < MAP_BYTES)
        begin
            mask = bfa_pkg::BIT_FIRST >> f[2:0];
            if (used)
                shadow_map[b] = shadow_map[b] | mask;
            else
                shadow_map[b] = shadow_map[b] & ~mask;
        end
    endfunction

    function automatic void mark_shadow_range(longint unsigned first, longint unsigned last,
                                              logic used);
        longint unsigned f;
        longint unsigned last_f;
        last_f = (last >= MAP_FRAMES) ? MAP_FRAMES - 1 : last;
        for (f = first; f <= last_f; f++)
            set_shadow_frame(f, used);
    endfunction

    function automatic frame_rsp_t predict_grant(frame_req_t r);
        frame_rsp_t  rsp;
        int unsigned b;
        logic [7:0]  v;
        bit          found;
        rsp.status = bfa_pkg::STATUS_OK;
        rsp.grant  = '0;
        case (r.op)
            bfa_pkg::OP_ALLOC:
            begin
                b = shadow_rover % MAP_BYTES;
                found = 1'b0;
                for (int n = 0; n < MAP_BYTES && !found; n++)
                begin
                    v = shadow_map[b];
                    if (v != bfa_pkg::BYTE_FULL)
                    begin
                        shadow_rover = b;
                        for (int i = 0; i < 8 && !found; i++)
                        begin
                            if (!v[7 - i])
                            begin
                                shadow_map[b] = v | (bfa_pkg::BIT_FIRST >> i);
                                rsp.grant = 15'(b * 8 + i);
                                found = 1'b1;
                            end
                        end
                    end
                    else
                        b = (b + 1) % MAP_BYTES;
                end
                if (!found)
                    rsp.status = bfa_pkg::STATUS_NO_FREE;
            end
            bfa_pkg::OP_FREE:
                set_shadow_frame(r.frame, 1'b0);
            bfa_pkg::OP_MARK_FREE:
                mark_shadow_range(r.start / FRAME_SZ, r.stop / FRAME_SZ, 1'b0);
            bfa_pkg::OP_MARK_USED:
                // round the end up in 64 bits: an end near 4G must not wrap
                mark_shadow_range(r.start / FRAME_SZ, (64'(r.stop) + FRAME_SZ - 1) / FRAME_SZ,
                                  1'b1);
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    function automatic void queue_item(bfa_pkg::op_t kind, int unsigned fr, logic [31:0] s,
                                       logic [31:0] e);
        frame_req_t r;
        r.op    = kind;
        r.frame = 15'(fr);
        r.start = s;
        r.stop  = e;
        req_q.push_back(r);
    endfunction

    // driver
    always @(negedge clk)
    begin
        case ((issued_cnt / PHASE_LEN) % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 66;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 66;
            end
            default:
            begin
                send_idle_pct  = 24;
                recv_stall_pct = 24;
            end
        endcase
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_req = req_q.pop_front();
                    op          <= cur_req.op;
                    frame_index <= cur_req.frame;
                    range_start <= cur_req.start;
                    range_end   <= cur_req.stop;
                    in_valid    <= 1'b1;
                    issued_cnt  = issued_cnt + 1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        frame_rsp_t want;
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
                grant_q.push_back(predict_grant(cur_req));
            if (out_valid && out_ready)
            begin
                if (grant_q.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: result transfer with none pending: status %0d frame %0d",
                                 $time, status, granted_frame);
                    mismatches++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (status !== want.status)
                        note_mismatch("status", want.status, status);
                    if (granted_frame !== want.grant)
                        note_mismatch("granted_frame", want.grant, granted_frame);
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("bitmap_frame_allocator_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        frame_req_t  r;
        int unsigned pick;
        int unsigned first;
        int unsigned span;

        for (int i = 0; i < MAP_BYTES; i++)
            shadow_map[i] = bfa_pkg::BYTE_FULL;
        shadow_rover = 0;

        // directed
        queue_item(bfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);   // map full after reset
        queue_item(bfa_pkg::OP_FREE, 0, $urandom, $urandom);
        queue_item(bfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
        queue_item(bfa_pkg::OP_FREE, 15'h7FFF, 32'hFFFF_FFFF, 32'h0);
        queue_item(bfa_pkg::OP_ALLOC, $urandom, 32'h0, 32'hFFFF_FFFF); // scans to last byte
        queue_item(bfa_pkg::OP_MARK_FREE, 0, 32'h0, 32'h0);
        queue_item(bfa_pkg::OP_ALLOC, 0, $urandom, $urandom);          // rover wraps to byte 0
        queue_item(bfa_pkg::OP_MARK_USED, 0, FRAME_SZ + 1, 2 * FRAME_SZ + 1);
        queue_item(bfa_pkg::OP_MARK_FREE, 0, 3 * FRAME_SZ, 13 * FRAME_SZ + FRAME_SZ - 1);
        queue_item(bfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
        queue_item(bfa_pkg::OP_MARK_FREE, 0, 8 * FRAME_SZ, 4 * FRAME_SZ);  // empty range
        queue_item(bfa_pkg::OP_MARK_USED, 0, 32'hFFFF_F000, 32'hFFFF_FFFF); // past the bitmap
        queue_item(bfa_pkg::OP_MARK_FREE, 15'h7FFF, 32'h7FFF_F000, 32'hFFFF_FFFF);
        queue_item(bfa_pkg::OP_MARK_USED, 0, 32'h0, 32'hFFFF_FFFF); // whole map, rounding carry
        queue_item(bfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
        queue_item(bfa_pkg::OP_FREE, 15'h5555, 32'h0, 32'h0);
        queue_item(bfa_pkg::OP_FREE, 15'h2AAA, 32'h0, 32'h0);
        queue_item(bfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
        queue_item(bfa_pkg::OP_MARK_FREE, 0, 32767 * FRAME_SZ, 32767 * FRAME_SZ + FRAME_SZ - 1);
        queue_item(bfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
        queue_item(bfa_pkg::OP_MARK_FREE, 0, 32'h0, 32'hFFFF_FFFF);  // whole map free
        queue_item(bfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
        queue_item(bfa_pkg::OP_MARK_USED, 0, 5 * FRAME_SZ, 5 * FRAME_SZ); // end on a boundary
        queue_item(bfa_pkg::OP_MARK_USED, 0, 5 * FRAME_SZ + 1, 6 * FRAME_SZ + 1);
        queue_item(bfa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);

        // random: mostly short ranges, rare whole-map sweeps and noise
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            pick    = $urandom_range(99);
            first   = $urandom_range(32'(MAP_FRAMES) + 63);
            span    = $urandom_range(40);
            r.frame = 15'($urandom);
            r.start = first * FRAME_SZ + $urandom_range(FRAME_SZ - 1);
            r.stop  = r.start + span * FRAME_SZ + $urandom_range(FRAME_SZ - 1);
            if ($urandom_range(19) == 0)
                r.stop = r.start - $urandom_range(2 * FRAME_SZ);
            if (pick < 40)
            begin
                r.op    = bfa_pkg::OP_ALLOC;
                r.start = $urandom;
                r.stop  = $urandom;
            end
            else if (pick < 58)
                r.op = bfa_pkg::OP_FREE;
            else if (pick < 78)
                r.op = bfa_pkg::OP_MARK_FREE;
            else if (pick < 97)
                r.op = bfa_pkg::OP_MARK_USED;
            else
            begin
                r.op    = pick[0] ? bfa_pkg::OP_MARK_FREE : bfa_pkg::OP_MARK_USED;
                r.start = $urandom;
                r.stop  = $urandom;
                if (pick < 99)
                begin
                    r.start = $urandom_range(FRAME_SZ - 1);
                    r.stop  = $urandom | 32'h0800_0000;
                end
            end
            req_q.push_back(r);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // checked at the rising edge, where the driver's updates have settled
        while (req_q.size() != 0 || in_valid || grant_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("bitmap_frame_allocator_top regression: pass");
        else
            $display("bitmap_frame_allocator_top regression: fail");
        $finish;
    end

endmodule
